// ===== sv/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication, checked at every clock edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants for the depth-first topological sorter.
// ----------------------------------------------------------------------------
package dfs_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int VW = $clog2(MaxVertices);      // vertex index width
  localparam int EW = $clog2(MaxEdges);         // edge index width
  localparam int LW = EW + 1;                   // link: 0 empty, else edge+1
  localparam int DW = $clog2(MaxVertices + 1);  // depth / count width
  localparam int GW = $clog2(MaxEdges + 1);     // in-degree width

  localparam logic KindEdge = 1'b0;
  localparam logic KindRun  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE_RD, ST_EDGE_WR, ST_SCAN, ST_SCAN_CHK, ST_TOP,
    ST_EDGE_LD, ST_TGT, ST_TGT_CHK, ST_EMIT, ST_CLEAR
  } state_t;
endpackage

// ===== sv/dfs_topological_sort_top.sv =====
// ----------------------------------------------------------------------------
// dfs_topological_sort_top
// Depth-first topological sorter over a graph of up to 64 vertices.
// ----------------------------------------------------------------------------
// Input beat: start with busy low. kind 0 adds edge from_vertex->to_vertex;
// kind 1 runs the sort. An edge beat reads the list head and degree, then
// writes them. A run scans the vertices, walks each list with an explicit
// stack and emits vertices in reverse finish order, one per cycle on
// out_valid, out_last on the final one. Every step goes through one
// sequencer and single-port RAMs for lists, degrees, edges and stacks; a
// closing pass clears list heads and in-degrees. Results cannot be stalled;
// out_valid lasts one cycle per result. Reset leaves an empty graph,
// vertex_count 0, and clears head/degree RAMs in a pass during which busy
// stays high (config still taken).
// Config: vertex_count at address 0 over the APB-style port.
module dfs_topological_sort_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_from_vertex,
  input  logic [7:0]  in_to_vertex,
  output logic        out_valid,
  output logic [6:0]  out_vertex,
  output logic        out_last,
  output logic        out_edges_dropped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int VW = dfs_pkg::VW;
  localparam int EW = dfs_pkg::EW;
  localparam int LW = dfs_pkg::LW;
  localparam int DW = dfs_pkg::DW;
  localparam int GW = dfs_pkg::GW;
  localparam int MaxV = dfs_pkg::MaxVertices;

  logic [6:0] cfg_vcount_r;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_vcount_r <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) cfg_vcount_r <= pwdata[6:0];
  end
  assign prdata = (paddr == 2'd0) ? {25'd0, cfg_vcount_r} : 32'd0;

  logic [6:0] n_act;
  assign n_act = (cfg_vcount_r > 7'(dfs_pkg::MaxVertices)) ?
                 7'(dfs_pkg::MaxVertices) : cfg_vcount_r;

  dfs_pkg::state_t st_r, st_nxt;
  logic [VW-1:0] a_r, a_nxt;        // from / target / scan vertex
  logic [VW-1:0] b_r, b_nxt;        // edge target
  logic [DW-1:0] vcnt_r, vcnt_nxt;  // scan / clear counter
  logic [DW-1:0] dep_r, dep_nxt;
  logic [DW-1:0] fin_r, fin_nxt;
  logic [EW:0]   etot_r, etot_nxt;
  logic          ovf_r, ovf_nxt;
  logic [MaxV-1:0] vis_r, vis_nxt;
  logic [LW-1:0] cur_r, cur_nxt;    // cursor of stack top
  logic          o_v_nxt, o_l_nxt;
  logic [6:0]    o_vx_nxt;
  logic          o_v_r, o_l_r, o_d_r;
  logic [6:0]    o_vx_r;

  // RAM ports
  logic          hd_we, dg_we, ed_we, ws_we, fs_we;
  logic [VW-1:0] hd_a, dg_a, ws_a, fs_a;
  logic [EW-1:0] ed_a;
  logic [LW-1:0] hd_wd, hd_rd;
  logic [GW-1:0] dg_wd, dg_rd;
  logic [VW+LW-1:0] ed_wd, ed_rd;
  logic [VW+LW-1:0] ws_wd, ws_rd;
  logic [VW-1:0] fs_wd, fs_rd;

  dfs_ram #(.Depth(MaxV), .Width(LW)) u_head (.clk, .we(hd_we), .addr(hd_a),
    .wdata(hd_wd), .rdata(hd_rd));
  dfs_ram #(.Depth(MaxV), .Width(GW)) u_deg (.clk, .we(dg_we), .addr(dg_a),
    .wdata(dg_wd), .rdata(dg_rd));
  dfs_ram #(.Depth(dfs_pkg::MaxEdges), .Width(VW+LW)) u_edge (.clk, .we(ed_we),
    .addr(ed_a), .wdata(ed_wd), .rdata(ed_rd));
  dfs_ram #(.Depth(MaxV), .Width(VW+LW)) u_walk (.clk, .we(ws_we), .addr(ws_a),
    .wdata(ws_wd), .rdata(ws_rd));
  dfs_ram #(.Depth(MaxV), .Width(VW)) u_fin (.clk, .we(fs_we), .addr(fs_a),
    .wdata(fs_wd), .rdata(fs_rd));

  logic [VW-1:0] top_idx;
  assign top_idx = VW'(dep_r - DW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dfs_pkg::ST_CLEAR;
      vcnt_r <= '0; dep_r <= '0; fin_r <= '0; etot_r <= '0; ovf_r <= 1'b0;
      vis_r <= '0; o_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      vcnt_r <= vcnt_nxt; dep_r <= dep_nxt; fin_r <= fin_nxt;
      etot_r <= etot_nxt; ovf_r <= ovf_nxt; vis_r <= vis_nxt; o_v_r <= o_v_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; cur_r <= cur_nxt;
    o_l_r <= o_l_nxt; o_vx_r <= o_vx_nxt; o_d_r <= ovf_r;
  end

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; vcnt_nxt = vcnt_r; dep_nxt = dep_r;
    fin_nxt = fin_r; etot_nxt = etot_r; ovf_nxt = ovf_r; vis_nxt = vis_r;
    cur_nxt = cur_r; o_v_nxt = 1'b0; o_l_nxt = 1'b0; o_vx_nxt = o_vx_r;
    hd_we = 1'b0; dg_we = 1'b0; ed_we = 1'b0; ws_we = 1'b0; fs_we = 1'b0;
    hd_a = a_r; dg_a = a_r; ed_a = cur_r[EW-1:0] - EW'(1);
    ws_a = top_idx; fs_a = VW'(fin_r);
    hd_wd = hd_rd; dg_wd = dg_rd; ed_wd = {b_r, hd_rd};
    ws_wd = {a_r, cur_r}; fs_wd = a_r;
    busy = (st_r != dfs_pkg::ST_IDLE);
    case (st_r)
      dfs_pkg::ST_IDLE: begin
        if (start) begin
          if (in_kind == dfs_pkg::KindEdge) begin
            if (in_from_vertex >= 8'd1 && in_from_vertex <= {1'b0, n_act} &&
                in_to_vertex >= 8'd1 && in_to_vertex <= {1'b0, n_act}) begin
              if (etot_r >= (EW+1)'(dfs_pkg::MaxEdges)) ovf_nxt = 1'b1;
              else begin
                a_nxt = VW'(in_from_vertex - 8'd1);
                b_nxt = VW'(in_to_vertex - 8'd1);
                hd_a = VW'(in_from_vertex - 8'd1);
                st_nxt = dfs_pkg::ST_EDGE_RD;
              end
            end
          end else begin
            vcnt_nxt = '0; fin_nxt = '0; dep_nxt = '0;
            st_nxt = dfs_pkg::ST_SCAN;
          end
        end
      end
      dfs_pkg::ST_EDGE_RD: begin
        dg_a = b_r;                      // degree data arrives next cycle
        st_nxt = dfs_pkg::ST_EDGE_WR;
      end
      dfs_pkg::ST_EDGE_WR: begin
        ed_we = 1'b1; ed_a = etot_r[EW-1:0];
        hd_we = 1'b1; hd_wd = LW'(etot_r) + LW'(1);
        dg_we = 1'b1; dg_a = b_r; dg_wd = dg_rd + GW'(1);
        etot_nxt = etot_r + (EW+1)'(1);
        st_nxt = dfs_pkg::ST_IDLE;
      end
      dfs_pkg::ST_SCAN: begin
        if (vcnt_r >= DW'(n_act)) begin
          st_nxt = (fin_r == '0) ? dfs_pkg::ST_CLEAR : dfs_pkg::ST_EMIT;
          vcnt_nxt = '0;
        end else begin
          a_nxt = VW'(vcnt_r); dg_a = VW'(vcnt_r); hd_a = VW'(vcnt_r);
          st_nxt = dfs_pkg::ST_SCAN_CHK;
        end
      end
      dfs_pkg::ST_SCAN_CHK: begin
        vcnt_nxt = vcnt_r + DW'(1);
        if (dg_rd == '0 && !vis_r[a_r]) begin
          vis_nxt[a_r] = 1'b1;
          ws_a = '0; ws_we = 1'b1; ws_wd = {a_r, hd_rd};
          cur_nxt = hd_rd; dep_nxt = DW'(1);
          st_nxt = dfs_pkg::ST_TOP;
        end else st_nxt = dfs_pkg::ST_SCAN;
      end
      dfs_pkg::ST_TOP: begin
        // cur_r and a_r hold the stack top
        if (cur_r == '0 || cur_r > LW'(dfs_pkg::MaxEdges)) begin
          if (fin_r < DW'(MaxV)) begin
            fs_we = 1'b1; fin_nxt = fin_r + DW'(1);
          end
          dep_nxt = dep_r - DW'(1);
          if (dep_r == DW'(1)) st_nxt = dfs_pkg::ST_SCAN;
          else begin
            ws_a = VW'(dep_r - DW'(2));
            st_nxt = dfs_pkg::ST_EDGE_LD;
            b_nxt = '0;
          end
        end else begin
          st_nxt = dfs_pkg::ST_TGT;  // edge read issued now
        end
      end
      dfs_pkg::ST_EDGE_LD: begin
        // popped: new top read back
        {a_nxt, cur_nxt} = ws_rd;
        st_nxt = dfs_pkg::ST_TOP;
      end
      dfs_pkg::ST_TGT: begin
        b_nxt = ed_rd[VW+LW-1:LW];
        cur_nxt = ed_rd[LW-1:0];
        ws_we = 1'b1; ws_wd = {a_r, ed_rd[LW-1:0]};
        hd_a = ed_rd[VW+LW-1:LW];
        st_nxt = dfs_pkg::ST_TGT_CHK;
      end
      dfs_pkg::ST_TGT_CHK: begin
        if (!vis_r[b_r] && dep_r < DW'(MaxV)) begin
          vis_nxt[b_r] = 1'b1;
          ws_a = VW'(dep_r); ws_we = 1'b1; ws_wd = {b_r, hd_rd};
          a_nxt = b_r; cur_nxt = hd_rd; dep_nxt = dep_r + DW'(1);
        end
        st_nxt = dfs_pkg::ST_TOP;
      end
      dfs_pkg::ST_EMIT: begin
        // fs read pipelined: address fin_r-1 issued, data next cycle
        fs_a = VW'(fin_r - DW'(1));
        if (vcnt_r != '0) begin
          o_v_nxt = 1'b1; o_vx_nxt = 7'(fs_rd) + 7'd1;
          o_l_nxt = (fin_r == '0);
        end
        if (fin_r == '0) begin
          st_nxt = dfs_pkg::ST_CLEAR; vcnt_nxt = '0;
        end else begin
          fin_nxt = fin_r - DW'(1);
          vcnt_nxt = vcnt_r + DW'(1);
        end
      end
      dfs_pkg::ST_CLEAR: begin
        hd_we = 1'b1; hd_a = VW'(vcnt_r); hd_wd = '0;
        dg_we = 1'b1; dg_a = VW'(vcnt_r); dg_wd = '0;
        vis_nxt = '0; etot_nxt = '0; fin_nxt = '0;
        if (vcnt_r == DW'(MaxV - 1)) begin
          st_nxt = dfs_pkg::ST_IDLE; vcnt_nxt = '0; ovf_nxt = 1'b0;
        end else vcnt_nxt = vcnt_r + DW'(1);
      end
      default: st_nxt = dfs_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = o_v_r;
  assign out_vertex = o_vx_r;
  assign out_last = o_l_r;
  assign out_edges_dropped = o_d_r;
endmodule

// ===== sv/dfs_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dfs_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic       out_last,
  input logic [6:0] out_vertex
);
  `ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy, "result beat while idle")
  `ASSERT_IMP(a_last_valid, clk, rst_n, out_last, out_valid, "last without beat")
  `ASSERT_IMP(a_vx_range, clk, rst_n, out_valid, out_vertex != 7'd0, "vertex zero")
  `ASSERT_NXT(a_last_end, clk, rst_n, out_last, !out_valid, "beat after last")
endmodule

bind dfs_topological_sort_top dfs_checker u_chk (.clk, .rst_n, .busy,
  .out_valid, .out_last, .out_vertex);

// ===== sim/tb_dfs_topological_sort_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dfs_topological_sort_top
// Drives edge and run commands into the sorter and checks every emitted
// vertex against a depth-first sort computed in the bench.
// ----------------------------------------------------------------------------

class topo_scoreboard;
  bit [5:0]  edge_dst [dfs_pkg::MaxEdges];
  bit [8:0]  edge_next [dfs_pkg::MaxEdges];
  bit [8:0]  head [dfs_pkg::MaxVertices];
  bit [8:0]  indeg [dfs_pkg::MaxVertices];
  bit        seen [dfs_pkg::MaxVertices];
  int        n_edges;
  bit        dropped;
  bit [6:0]  vcount;
  bit [6:0]  exp_vertex [$];
  bit        exp_last [$];
  bit        exp_drop [$];
  int        errors;

  function void clear();
    foreach (head[i]) begin
      head[i] = 0; indeg[i] = 0; seen[i] = 0;
    end
    n_edges = 0;
    dropped = 0;
  endfunction

  function void note_beat(bit kind, bit [7:0] f, bit [7:0] t);
    int n;
    int order [$];
    int stk [$];
    int cur [$];
    int top;
    int e;
    int d;
    n = (int'(vcount) > dfs_pkg::MaxVertices) ? dfs_pkg::MaxVertices : int'(vcount);
    if (kind == dfs_pkg::KindEdge) begin
      if (f < 8'd1 || int'(f) > n || t < 8'd1 || int'(t) > n) return;
      if (n_edges >= dfs_pkg::MaxEdges) begin
        dropped = 1;
        return;
      end
      edge_dst[n_edges] = 6'(t - 8'd1);
      edge_next[n_edges] = head[6'(f - 8'd1)];
      head[6'(f - 8'd1)] = 9'(n_edges + 1);
      indeg[6'(t - 8'd1)]++;
      n_edges++;
      return;
    end
    for (int s = 0; s < n; s++) begin
      if (indeg[s] == 0 && !seen[s]) begin
        seen[s] = 1;
        stk = {s};
        cur = {int'(head[s])};
        while (stk.size() > 0) begin
          top = stk.size() - 1;
          if (cur[top] == 0) begin
            if (order.size() < dfs_pkg::MaxVertices) order = {order, stk[top]};
            void'(stk.pop_back());
            void'(cur.pop_back());
          end else begin
            e = cur[top] - 1;
            d = int'(edge_dst[e]);
            cur[top] = int'(edge_next[e]);
            if (!seen[d] && stk.size() < dfs_pkg::MaxVertices) begin
              seen[d] = 1;
              stk = {stk, d};
              cur = {cur, int'(head[d])};
            end
          end
        end
      end
    end
    for (int k = order.size() - 1; k >= 0; k--) begin
      exp_vertex = {exp_vertex, 7'(order[k] + 1)};
      exp_last = {exp_last, k == 0};
      exp_drop = {exp_drop, dropped};
    end
    clear();
  endfunction

  function void check_result(bit [6:0] v, bit l, bit dr);
    bit [6:0] ev;
    bit el;
    bit ed;
    if (exp_vertex.size() == 0) begin
      $display("%0t: unexpected vertex %0d", $time, v);
      errors++;
      return;
    end
    ev = exp_vertex.pop_front();
    el = exp_last.pop_front();
    ed = exp_drop.pop_front();
    if (v !== ev) begin
      $display("%0t: vertex exp %0d got %0d", $time, ev, v);
      errors++;
    end
    if (l !== el) begin
      $display("%0t: last exp %0b got %0b", $time, el, l);
      errors++;
    end
    if (dr !== ed) begin
      $display("%0t: edges_dropped exp %0b got %0b", $time, ed, dr);
      errors++;
    end
  endfunction
endclass

module tb_dfs_topological_sort_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_kind = 0;
  logic [7:0]  in_from_vertex = 0;
  logic [7:0]  in_to_vertex = 0;
  logic        out_valid;
  logic [6:0]  out_vertex;
  logic        out_last;
  logic        out_edges_dropped;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic [1:0] AddrVertexCount = 2'd0;

  topo_scoreboard sb = new();
  bit calm;

  dfs_topological_sort_top u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_vertex, out_last, out_edges_dropped);
  end

  task automatic write_vertex_count(bit [6:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= AddrVertexCount; pwdata <= {25'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.vcount = val;
  endtask

  task automatic send(bit kind, int f, int t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1; in_kind <= kind; in_from_vertex <= 8'(f); in_to_vertex <= 8'(t);
    do @(posedge clk); while (busy);
    sb.note_beat(kind, 8'(f), 8'(t));
  endtask

  task automatic drain();
    start <= 0;
    while (sb.exp_vertex.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic random_graph(int n_edges, int n);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(dfs_pkg::KindEdge, $urandom_range(0, 255), $urandom_range(0, 255));
      else
        send(dfs_pkg::KindEdge, $urandom_range(1, n), $urandom_range(1, n));
    end
    send(dfs_pkg::KindRun, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int n;
    sb.clear();
    sb.vcount = 7'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // no vertices: all edges ignored, empty run
    send(dfs_pkg::KindEdge, 1, 2);
    send(dfs_pkg::KindRun, 0, 0);
    drain();
    write_vertex_count(7'd64);
    send(dfs_pkg::KindEdge, 64, 1); send(dfs_pkg::KindEdge, 1, 2);
    send(dfs_pkg::KindEdge, 2, 3); send(dfs_pkg::KindEdge, 3, 1);
    send(dfs_pkg::KindEdge, 0, 5); send(dfs_pkg::KindEdge, 65, 5);
    send(dfs_pkg::KindEdge, 255, 255); send(dfs_pkg::KindEdge, 5, 0);
    send(dfs_pkg::KindEdge, 64, 63); send(dfs_pkg::KindEdge, 64, 62);
    send(dfs_pkg::KindRun, 255, 0);
    drain();
    // pure cycle: nothing emitted
    write_vertex_count(7'd3);
    send(dfs_pkg::KindEdge, 1, 2); send(dfs_pkg::KindEdge, 2, 3);
    send(dfs_pkg::KindEdge, 3, 1);
    send(dfs_pkg::KindRun, 0, 0);
    drain();
    // above the maximum, then lowered with edges stored
    write_vertex_count(7'd127);
    send(dfs_pkg::KindEdge, 10, 64); send(dfs_pkg::KindEdge, 64, 2);
    drain();
    write_vertex_count(7'd12);
    send(dfs_pkg::KindEdge, 1, 10);
    send(dfs_pkg::KindRun, 0, 0);
    drain();
    // overflow the edge store
    write_vertex_count(7'd40);
    for (int i = 0; i < 258; i++)
      send(dfs_pkg::KindEdge, $urandom_range(1, 40), $urandom_range(1, 40));
    send(dfs_pkg::KindRun, 0, 0);
    drain();
    for (int r = 0; r < 4; r++) begin
      if (r == 3) calm = 1;
      n = (r % 2 == 0) ? $urandom_range(1, 64) : $urandom_range(1, 10);
      write_vertex_count(7'(n));
      random_graph($urandom_range(0, 10), n);
      drain();
    end
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
